[src/aipc_pkg.sv]
// Shared types, codes and the pattern table for the ARM PC-use classifier.
package aipc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned NPAT   = 34;

  localparam logic [3:0] PC_REG = 4'hF;
  localparam logic [3:0] SP_REG = 4'd13;
  localparam logic [3:0] LR_REG = 4'd14;

  // Relocation template codes
  localparam logic [CODE_W-1:0] T_NONE        = 4'd0;
  localparam logic [CODE_W-1:0] T_GENERIC     = 4'd1;
  localparam logic [CODE_W-1:0] T_DP_RN       = 4'd2;
  localparam logic [CODE_W-1:0] T_DP_RN2      = 4'd3;
  localparam logic [CODE_W-1:0] T_DP_RD_RN    = 4'd4;
  localparam logic [CODE_W-1:0] T_DP_RD_RM    = 4'd5;
  localparam logic [CODE_W-1:0] T_DP_RM       = 4'd6;
  localparam logic [CODE_W-1:0] T_DP_RM2      = 4'd7;
  localparam logic [CODE_W-1:0] T_DP_RN_RM    = 4'd8;
  localparam logic [CODE_W-1:0] T_DP_RN_RM2   = 4'd9;
  localparam logic [CODE_W-1:0] T_DP_RD_RN_RM = 4'd10;
  localparam logic [CODE_W-1:0] T_BLX_REG     = 4'd11;
  localparam logic [CODE_W-1:0] T_BLX_IMM     = 4'd12;
  localparam logic [CODE_W-1:0] T_B           = 4'd13;
  localparam logic [CODE_W-1:0] T_BL          = 4'd14;

  // No-PC flag bits
  localparam logic [3:0] F_RN = 4'b1000;
  localparam logic [3:0] F_RD = 4'b0100;
  localparam logic [3:0] F_RS = 4'b0010;
  localparam logic [3:0] F_RM = 4'b0001;

  typedef enum logic [3:0] {
    K_NONE, K_BLX_IMM, K_NOPC, K_BX, K_DP, K_LS, K_LSM,
    K_B, K_BL, K_EXTRA, K_DUAL, K_GENERIC
  } kind_e;

  localparam logic [WORD_W-1:0] PAT_MASK [NPAT] = '{
    32'hF8000000, 32'hFE000000, 32'hFF000000, 32'hFE000000, 32'hF0000000,
    32'h0FB00000, 32'h0E000010, 32'h0FB000F0, 32'h0FB000F0, 32'h0FF000F0,
    32'h0FF000F0, 32'h0FF000F0, 32'h0F9000F0, 32'h0E000010, 32'h0E000090,
    32'h0E000000, 32'h0E000000, 32'h0E000010, 32'h0E000000, 32'h0F000000,
    32'h0F000000, 32'h0FF000F0, 32'h0F900090, 32'h0FC000F0, 32'h0F8000F0,
    32'h0FB000F0, 32'h0F8000F0, 32'h0E4000F0, 32'h0E4000F0, 32'h0E5000D0,
    32'h0E5000D0, 32'h0E5000D0, 32'h0E5000D0, 32'h0F000000
  };

  localparam logic [WORD_W-1:0] PAT_VALUE [NPAT] = '{
    32'hF0000000, 32'hF8000000, 32'hFF000000, 32'hFA000000, 32'hF0000000,
    32'h03000000, 32'h06000010, 32'h01000000, 32'h01200000, 32'h01200010,
    32'h01600010, 32'h01200030, 32'h01000050, 32'h00000000, 32'h00000010,
    32'h02000000, 32'h04000000, 32'h06000000, 32'h08000000, 32'h0A000000,
    32'h0B000000, 32'h01200070, 32'h01000080, 32'h00000090, 32'h00800090,
    32'h01000090, 32'h01800090, 32'h000000B0, 32'h004000B0, 32'h001000D0,
    32'h005000D0, 32'h000000D0, 32'h004000D0, 32'h0F000000
  };

  localparam kind_e PAT_KIND [NPAT] = '{
    K_NONE, K_NONE, K_NONE, K_BLX_IMM, K_NONE,
    K_NONE, K_NONE, K_NOPC, K_NOPC, K_BX,
    K_NOPC, K_BX, K_NONE, K_DP, K_DP,
    K_DP, K_LS, K_LS, K_LSM, K_B,
    K_BL, K_NONE, K_NONE, K_NOPC, K_NOPC,
    K_NOPC, K_NOPC, K_EXTRA, K_EXTRA, K_EXTRA,
    K_EXTRA, K_DUAL, K_DUAL, K_GENERIC
  };

  localparam logic [3:0] PAT_FLAGS [NPAT] = '{
    4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
    4'h0, 4'h0, F_RD | F_RM, F_RM, 4'h0,
    F_RD | F_RM, 4'h0, 4'h0, 4'h0, 4'h0,
    4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
    4'h0, 4'h0, 4'h0, F_RN | F_RD | F_RS | F_RM, F_RN | F_RD | F_RS | F_RM,
    F_RN | F_RD | F_RM, F_RN | F_RD | F_RM, 4'h0, 4'h0, 4'h0,
    4'h0, 4'h0, 4'h0, 4'h0
  };

  // Stage 1 result: matched class
  typedef struct packed {
    logic [WORD_W-1:0] word;
    kind_e             kind;
    logic [3:0]        flags;
  } match_t;

  // Stage 2 result: field compares and raw bits the class rules need
  typedef struct packed {
    kind_e      kind;
    logic [3:0] flags;
    logic [3:0] op;
    logic       pd;
    logic       pn;
    logic       pm;
    logic       ps;
    logic       rd_sp;
    logic       rd_lr;
    logic       rd_odd;
    logic       rd_eq_rn;
    logic       rd_eq_rm;
    logic       rm_eq_rn;
    logic       wb;
    logic       b25;
    logic       b22;
    logic       b21;
    logic       b20;
    logic       b5;
    logic       list_zero;
    logic       list_rn;
    logic       list_pc;
  } pred_t;

endpackage

[src/aipc_if.sv]
// Valid/ready channel interfaces for instruction words and template codes.
interface aipc_in_if;
  logic                       valid;
  logic                       ready;
  logic [aipc_pkg::WORD_W-1:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface aipc_out_if;
  logic                       valid;
  logic                       ready;
  logic [aipc_pkg::CODE_W-1:0] template_code;
  logic                       supported;

  modport source (output valid, output template_code, output supported, input ready);
  modport sink   (input valid, input template_code, input supported, output ready);
endinterface

[src/arm_insn_pc_use_classifier_unit.sv]
// Top level of the ARM instruction PC-use classifier: three-stage pipeline.
//
//   channel  dir  payload                     handshake
//   in_i     in   instruction_word[31:0]      valid/ready
//   out_o    out  template_code[3:0], supported  valid/ready
//
// Stages: an item passes through the match, compare and rule registers in order,
// and one item can enter every cycle while the output is not stalled.
// Reset: rst_ni clears only the stage valid bits; nothing else is kept.
// Stalls: when the output register holds an item the sink does not take,
// all three stages hold together and in_i.ready drops; nothing is lost.
module arm_insn_pc_use_classifier_unit (
  input  logic clk_i,
  input  logic rst_ni,
  aipc_in_if.sink    in_i,
  aipc_out_if.source out_o
);
  import aipc_pkg::*;

  logic   adv;
  logic   s1_valid, s2_valid, s3_valid;
  match_t s1_match;
  pred_t  s2_pred;

  // Advance the whole pipe unless the finished item is waiting at the output
  assign adv        = !s3_valid || out_o.ready;
  assign in_i.ready = adv;

  // Match the word against the ordered pattern list
  aipc_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_i.valid),
    .word_i  (in_i.instruction_word),
    .valid_o (s1_valid),
    .match_o (s1_match)
  );

  // Compare register fields against the PC and each other
  aipc_pred u_pred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s1_valid),
    .match_i (s1_match),
    .valid_o (s2_valid),
    .pred_o  (s2_pred)
  );

  // Apply the class rules and hold the result for the sink
  aipc_code u_code (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (s2_valid),
    .pred_i      (s2_pred),
    .valid_o     (s3_valid),
    .code_o      (out_o.template_code),
    .supported_o (out_o.supported)
  );

  assign out_o.valid = s3_valid;
endmodule

[src/aipc_match.sv]
// Stage 1: first-match search over the ordered pattern table.
module aipc_match (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic [aipc_pkg::WORD_W-1:0] word_i,
  output logic                        valid_o,
  output aipc_pkg::match_t            match_o
);
  import aipc_pkg::*;

  logic   valid_q;
  match_t match_d, match_q;

  // Walk from the last pattern back so the earliest match wins
  always_comb begin
    match_d.word  = word_i;
    match_d.kind  = K_NONE;
    match_d.flags = 4'h0;
    for (int i = NPAT - 1; i >= 0; i--) begin
      if ((word_i & PAT_MASK[i]) == PAT_VALUE[i]) begin
        match_d.kind  = PAT_KIND[i];
        match_d.flags = PAT_FLAGS[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      match_q <= match_d;
    end
  end

  assign valid_o = valid_q;
  assign match_o = match_q;
endmodule

[src/aipc_pred.sv]
// Stage 2: register-field compares for the class rules.
module aipc_pred (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  aipc_pkg::match_t  match_i,
  output logic              valid_o,
  output aipc_pkg::pred_t   pred_o
);
  import aipc_pkg::*;

  logic       valid_q;
  pred_t      pred_d, pred_q;
  logic [3:0] rd, rn, rm, rs;
  logic [15:0] list;

  always_comb begin
    rn   = match_i.word[19:16];
    rd   = match_i.word[15:12];
    rs   = match_i.word[11:8];
    rm   = match_i.word[3:0];
    list = match_i.word[15:0];

    pred_d.kind      = match_i.kind;
    pred_d.flags     = match_i.flags;
    pred_d.op        = match_i.word[24:21];
    pred_d.pd        = (rd == PC_REG);
    pred_d.pn        = (rn == PC_REG);
    pred_d.pm        = (rm == PC_REG);
    pred_d.ps        = (rs == PC_REG);
    pred_d.rd_sp     = (rd == SP_REG);
    pred_d.rd_lr     = (rd == LR_REG);
    pred_d.rd_odd    = rd[0];
    pred_d.rd_eq_rn  = (rd == rn);
    pred_d.rd_eq_rm  = (rd == rm);
    pred_d.rm_eq_rn  = (rm == rn);
    pred_d.wb        = !match_i.word[24] || match_i.word[21];
    pred_d.b25       = match_i.word[25];
    pred_d.b22       = match_i.word[22];
    pred_d.b21       = match_i.word[21];
    pred_d.b20       = match_i.word[20];
    pred_d.b5        = match_i.word[5];
    pred_d.list_zero = (list == 16'h0000);
    pred_d.list_rn   = list[rn];
    pred_d.list_pc   = list[15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pred_q <= pred_d;
    end
  end

  assign valid_o = valid_q;
  assign pred_o  = pred_q;
endmodule

[src/aipc_code.sv]
// Stage 3: per-class rules that pick the template code; output register.
module aipc_code (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  aipc_pkg::pred_t             pred_i,
  output logic                        valid_o,
  output logic [aipc_pkg::CODE_W-1:0] code_o,
  output logic                        supported_o
);
  import aipc_pkg::*;

  logic              valid_q;
  logic [CODE_W-1:0] code_d, code_q;
  logic [CODE_W-1:0] dp_code, ls_code, lsm_code, ext_code, dual_code, nopc_code, bx_code;
  logic              use_rd, use_rn;

  // Data processing
  always_comb begin
    use_rd = (pred_i.op[3:2] != 2'b10);
    use_rn = !use_rd || !(pred_i.op == 4'hD || pred_i.op == 4'hF);
    if (pred_i.b25) begin
      if (!use_rn || !pred_i.pn)      dp_code = T_GENERIC;
      else if (!use_rd)               dp_code = T_DP_RN2;
      else                            dp_code = pred_i.pd ? T_DP_RD_RN : T_DP_RN;
    end else if (!use_rn) begin
      if (!pred_i.pm)                 dp_code = T_GENERIC;
      else                            dp_code = pred_i.pd ? T_DP_RD_RM : T_DP_RM;
    end else if (!use_rd) begin
      if (pred_i.pn)                  dp_code = pred_i.pm ? T_DP_RN_RM2 : T_DP_RN2;
      else                            dp_code = pred_i.pm ? T_DP_RM2 : T_GENERIC;
    end else if (pred_i.pd) begin
      if (pred_i.pn)                  dp_code = pred_i.pm ? T_DP_RD_RN_RM : T_DP_RD_RN;
      else                            dp_code = pred_i.pm ? T_DP_RD_RM : T_GENERIC;
    end else if (pred_i.pn) begin
      if (pred_i.pm)                  dp_code = T_DP_RN_RM;
      else if (pred_i.rd_sp)          dp_code = T_NONE;
      else                            dp_code = pred_i.rd_eq_rm ? T_DP_RN2 : T_DP_RN;
    end else if (pred_i.pm) begin
      if (pred_i.rd_sp)               dp_code = T_NONE;
      else                            dp_code = pred_i.rd_eq_rn ? T_DP_RM2 : T_DP_RM;
    end else begin
      dp_code = T_GENERIC;
    end
  end

  // Loads, stores and their multiple, extra and dual forms; no-PC and BX classes
  always_comb begin
    if (pred_i.wb && pred_i.pn)                              ls_code = T_NONE;
    else if (pred_i.b25 && (pred_i.pm || pred_i.rm_eq_rn))   ls_code = T_NONE;
    else if (pred_i.pd && pred_i.pn)                         ls_code = T_NONE;
    else if (!pred_i.b20 && pred_i.pd)                       ls_code = T_NONE;
    else                                 ls_code = pred_i.pn ? T_DP_RN : T_GENERIC;

    if (pred_i.list_zero || pred_i.pn)                       lsm_code = T_NONE;
    else if (pred_i.b20)  lsm_code = (pred_i.list_rn && pred_i.b21) ? T_NONE : T_GENERIC;
    else                  lsm_code = pred_i.list_pc ? T_NONE : T_GENERIC;

    if (pred_i.rd_eq_rn || pred_i.pd)                        ext_code = T_NONE;
    else if (!pred_i.b22 && pred_i.pm)                       ext_code = T_NONE;
    else                                 ext_code = pred_i.pn ? T_DP_RN : T_GENERIC;

    dual_code = (pred_i.rd_odd || pred_i.rd_lr) ? T_NONE : ext_code;

    if ((pred_i.flags[3] && pred_i.pn) || (pred_i.flags[2] && pred_i.pd) ||
        (pred_i.flags[1] && pred_i.ps) || (pred_i.flags[0] && pred_i.pm)) begin
      nopc_code = T_NONE;
    end else begin
      nopc_code = T_GENERIC;
    end

    if (pred_i.pm) bx_code = T_NONE;
    else           bx_code = pred_i.b5 ? T_BLX_REG : T_GENERIC;
  end

  always_comb begin
    case (pred_i.kind)
      K_BLX_IMM: code_d = T_BLX_IMM;
      K_NOPC:    code_d = nopc_code;
      K_BX:      code_d = bx_code;
      K_DP:      code_d = dp_code;
      K_LS:      code_d = ls_code;
      K_LSM:     code_d = lsm_code;
      K_B:       code_d = T_B;
      K_BL:      code_d = T_BL;
      K_EXTRA:   code_d = ext_code;
      K_DUAL:    code_d = dual_code;
      K_GENERIC: code_d = T_GENERIC;
      default:   code_d = T_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      code_q <= code_d;
    end
  end

  assign valid_o     = valid_q;
  assign code_o      = code_q;
  assign supported_o = (code_q != T_NONE);
endmodule

[dv/tb_arm_insn_pc_use_classifier_unit.sv]
// Testbench for the ARM instruction PC-use classifier: directed words, then shaped random words.
`timescale 1ns / 1ps

module tb_arm_insn_pc_use_classifier_unit;
  import aipc_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 8;     // pipeline is three deep; leave margin
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the watchdog ends the run
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASE_A = 700;
  localparam int RANDOM_PHASE_B = 500;
  localparam int RANDOM_PHASE_C = 400;

  // Data-processing opcodes that change which registers count as read or written
  localparam logic [3:0] OP_TST = 4'h8;
  localparam logic [3:0] OP_CMN = 4'hB;
  localparam logic [3:0] OP_MOV = 4'hD;
  localparam logic [3:0] OP_MVN = 4'hF;

  // Marks a directed row whose template comes from the predictor
  localparam int BY_PREDICTOR = -1;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              supported;
  } verdict_t;

  // Directed rows: extremes, each instruction class, shadowed encodings, empty list.
  localparam int NDIR = 26;
  localparam logic [WORD_W-1:0] DIR_WORD [NDIR] = '{
    32'h00000000, 32'hFFFFFFFF, 32'hFA000000, 32'hF5D0F000, 32'hEA000000,
    32'h0BFFFFFF, 32'hE3000000, 32'hE6000010, 32'hE1000050, 32'hE8BD0000,
    32'hE12FFF1E, 32'hE12FFF33, 32'hE12FFF3F, 32'hE08FF00F, 32'hE28FF004,
    32'hE1A0F00F, 32'hE35F0000, 32'hE59FF000, 32'hE8BD8000, 32'hE1CF00D8,
    32'hE1C0F0D0, 32'hE1DF00B0, 32'hE0000F9F, 32'hE1200070, 32'hE1000080,
    32'hEF000000
  };
  localparam int DIR_CODE [NDIR] = '{
    T_GENERIC, T_NONE, T_BLX_IMM, T_NONE, T_B,
    T_BL, T_NONE, T_NONE, T_NONE, T_NONE,
    BY_PREDICTOR, BY_PREDICTOR, BY_PREDICTOR, BY_PREDICTOR, BY_PREDICTOR,
    BY_PREDICTOR, BY_PREDICTOR, BY_PREDICTOR, BY_PREDICTOR, BY_PREDICTOR,
    BY_PREDICTOR, BY_PREDICTOR, BY_PREDICTOR, BY_PREDICTOR, BY_PREDICTOR,
    BY_PREDICTOR
  };

  logic clk_i;
  logic rst_ni;

  aipc_in_if  in_ch ();
  aipc_out_if out_ch ();

  arm_insn_pc_use_classifier_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Expected templates in acceptance order, oldest at the front
  verdict_t    template_q [$];
  int          row_code;        // travels with the word: typed template or BY_PREDICTOR
  bit          src_idle_on;
  bit          snk_stall_on;
  int          fail_count;
  int          words_in;
  int          results_checked;
  int          quiet_cycles;
  logic [15:0] codes_seen;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit pattern_hit(input logic [31:0] w, input logic [31:0] m,
                                     input logic [31:0] v);
    return (w & m) == v;
  endfunction

  // Predict the template: first matching pattern picks the class, class rules pick the code.
  function automatic logic [CODE_W-1:0] classify_insn(input logic [WORD_W-1:0] w);
    kind_e       k;
    logic [3:0]  fl, op, rd, rn, rm, rs;
    logic        use_rd, use_rn, pd, pn, pm, wb;
    logic [15:0] regs;
    fl = 4'h0;
    if      (pattern_hit(w, 32'hF8000000, 32'hF0000000)) k = K_NONE;
    else if (pattern_hit(w, 32'hFE000000, 32'hF8000000)) k = K_NONE;
    else if (pattern_hit(w, 32'hFF000000, 32'hFF000000)) k = K_NONE;
    else if (pattern_hit(w, 32'hFE000000, 32'hFA000000)) k = K_BLX_IMM;
    else if (pattern_hit(w, 32'hF0000000, 32'hF0000000)) k = K_NONE;
    else if (pattern_hit(w, 32'h0FB00000, 32'h03000000)) k = K_NONE;
    else if (pattern_hit(w, 32'h0E000010, 32'h06000010)) k = K_NONE;
    else if (pattern_hit(w, 32'h0FB000F0, 32'h01000000)) begin k = K_NOPC; fl = F_RD | F_RM; end
    else if (pattern_hit(w, 32'h0FB000F0, 32'h01200000)) begin k = K_NOPC; fl = F_RM; end
    else if (pattern_hit(w, 32'h0FF000F0, 32'h01200010)) k = K_BX;
    else if (pattern_hit(w, 32'h0FF000F0, 32'h01600010)) begin k = K_NOPC; fl = F_RD | F_RM; end
    else if (pattern_hit(w, 32'h0FF000F0, 32'h01200030)) k = K_BX;
    else if (pattern_hit(w, 32'h0F9000F0, 32'h01000050)) k = K_NONE;
    else if (pattern_hit(w, 32'h0E000010, 32'h00000000)) k = K_DP;
    else if (pattern_hit(w, 32'h0E000090, 32'h00000010)) k = K_DP;
    else if (pattern_hit(w, 32'h0E000000, 32'h02000000)) k = K_DP;
    else if (pattern_hit(w, 32'h0E000000, 32'h04000000)) k = K_LS;
    else if (pattern_hit(w, 32'h0E000010, 32'h06000000)) k = K_LS;
    else if (pattern_hit(w, 32'h0E000000, 32'h08000000)) k = K_LSM;
    else if (pattern_hit(w, 32'h0F000000, 32'h0A000000)) k = K_B;
    else if (pattern_hit(w, 32'h0F000000, 32'h0B000000)) k = K_BL;
    // breakpoint and DSP multiply: never reached first, kept for order
    else if (pattern_hit(w, 32'h0FF000F0, 32'h01200070)) k = K_NONE;
    else if (pattern_hit(w, 32'h0F900090, 32'h01000080)) k = K_NONE;
    else if (pattern_hit(w, 32'h0FC000F0, 32'h00000090)) begin
      k = K_NOPC; fl = F_RN | F_RD | F_RS | F_RM;
    end
    else if (pattern_hit(w, 32'h0F8000F0, 32'h00800090)) begin
      k = K_NOPC; fl = F_RN | F_RD | F_RS | F_RM;
    end
    else if (pattern_hit(w, 32'h0FB000F0, 32'h01000090)) begin
      k = K_NOPC; fl = F_RN | F_RD | F_RM;
    end
    else if (pattern_hit(w, 32'h0F8000F0, 32'h01800090)) begin
      k = K_NOPC; fl = F_RN | F_RD | F_RM;
    end
    else if (pattern_hit(w, 32'h0E4000F0, 32'h000000B0)) k = K_EXTRA;
    else if (pattern_hit(w, 32'h0E4000F0, 32'h004000B0)) k = K_EXTRA;
    else if (pattern_hit(w, 32'h0E5000D0, 32'h001000D0)) k = K_EXTRA;
    else if (pattern_hit(w, 32'h0E5000D0, 32'h005000D0)) k = K_EXTRA;
    else if (pattern_hit(w, 32'h0E5000D0, 32'h000000D0)) k = K_DUAL;
    else if (pattern_hit(w, 32'h0E5000D0, 32'h004000D0)) k = K_DUAL;
    else if (pattern_hit(w, 32'h0F000000, 32'h0F000000)) k = K_GENERIC;
    else k = K_NONE;

    op = w[24:21];
    rn = w[19:16];
    rd = w[15:12];
    rs = w[11:8];
    rm = w[3:0];
    pd = rd == PC_REG;
    pn = rn == PC_REG;
    pm = rm == PC_REG;
    regs = w[15:0];

    case (k)
      K_BLX_IMM: return T_BLX_IMM;
      K_B:       return T_B;
      K_BL:      return T_BL;
      K_GENERIC: return T_GENERIC;
      K_NOPC: begin
        if ((fl & F_RN) != 4'h0 && pn) return T_NONE;
        if ((fl & F_RD) != 4'h0 && pd) return T_NONE;
        if ((fl & F_RS) != 4'h0 && rs == PC_REG) return T_NONE;
        if ((fl & F_RM) != 4'h0 && pm) return T_NONE;
        return T_GENERIC;
      end
      K_BX: begin
        if (pm) return T_NONE;
        return w[5] ? T_BLX_REG : T_GENERIC;
      end
      K_DP: begin
        // compares and tests write no rd; moves read no rn
        use_rd = !(op >= OP_TST && op <= OP_CMN);
        use_rn = !use_rd || !(op == OP_MOV || op == OP_MVN);
        if (w[25]) begin
          if (!use_rn || !pn) return T_GENERIC;
          if (!use_rd) return T_DP_RN2;
          return pd ? T_DP_RD_RN : T_DP_RN;
        end
        if (!use_rn) begin
          if (!pm) return T_GENERIC;
          return pd ? T_DP_RD_RM : T_DP_RM;
        end
        if (!use_rd) begin
          if (pn) return pm ? T_DP_RN_RM2 : T_DP_RN2;
          return pm ? T_DP_RM2 : T_GENERIC;
        end
        if (pd) begin
          if (pn) return pm ? T_DP_RD_RN_RM : T_DP_RD_RN;
          return pm ? T_DP_RD_RM : T_GENERIC;
        end
        if (pn) begin
          if (pm) return T_DP_RN_RM;
          if (rd == SP_REG) return T_NONE;
          return (rd != rm) ? T_DP_RN : T_DP_RN2;
        end
        if (pm) begin
          if (rd == SP_REG) return T_NONE;
          return (rd != rn) ? T_DP_RM : T_DP_RM2;
        end
        return T_GENERIC;
      end
      K_LS: begin
        wb = !w[24] || w[21];
        if (wb && pn) return T_NONE;
        if (w[25] && (pm || rm == rn)) return T_NONE;
        if (pd && pn) return T_NONE;
        if (!w[20] && pd) return T_NONE;
        return pn ? T_DP_RN : T_GENERIC;
      end
      K_LSM: begin
        if (regs == 16'h0000 || pn) return T_NONE;
        if (w[20]) begin
          if (regs[rn] && w[21]) return T_NONE;
        end else if (regs[15]) begin
          return T_NONE;
        end
        return T_GENERIC;
      end
      K_EXTRA, K_DUAL: begin
        // dual transfers need an even register pair below lr
        if (k == K_DUAL && (rd[0] || rd == LR_REG)) return T_NONE;
        if (rd == rn || pd) return T_NONE;
        if (!w[22] && pm) return T_NONE;
        return pn ? T_DP_RN : T_GENERIC;
      end
      default: return T_NONE;
    endcase
  endfunction

  // Shape random words toward deep behavior: mostly conditional words with
  // register fields pulled toward pc, sp, lr and each other; a tenth pure noise.
  function automatic logic [WORD_W-1:0] shape_insn_word();
    logic [WORD_W-1:0] w;
    int                lo;
    int                pick;
    w = $urandom();
    if ($urandom_range(0, 9) == 0) return w;
    if ($urandom_range(0, 7) != 0) w[31:28] = 4'($urandom_range(0, 14));
    if ($urandom_range(0, 2) == 0) w[27:25] = 3'b000;
    // bias toward multiply and extra load/store encodings
    if ($urandom_range(0, 3) == 0) w[7:4] = {1'b1, 2'($urandom_range(0, 3)), 1'b1};
    for (int f = 0; f < 4; f++) begin
      lo   = (f == 0) ? 0 : 4 + 4 * f;  // rm, rs, rd, rn
      pick = $urandom_range(0, 11);
      if (pick < 4)       w[lo +: 4] = PC_REG;
      else if (pick == 4) w[lo +: 4] = SP_REG;
      else if (pick == 5) w[lo +: 4] = LR_REG;
    end
    if ($urandom_range(0, 5) == 0) w[15:12] = w[19:16];
    if ($urandom_range(0, 5) == 0) w[3:0]   = w[19:16];
    if ($urandom_range(0, 7) == 0) w[3:0]   = w[15:12];
    if ($urandom_range(0, 15) == 0) w[15:0] = 16'h0000;
    return w;
  endfunction

  // Offer one word; hold it until accepted. An idle burst may come first.
  task automatic offer_word(input logic [WORD_W-1:0] w, input int code);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.instruction_word <= w;
    row_code               <= code;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait out every pending template.
  task automatic drain_templates();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (template_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  // Sink side: random stall bursts while enabled, otherwise always ready.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (snk_stall_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Record a template per accepted word; check each accepted result against the oldest.
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    verdict_t got;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      if (row_code == BY_PREDICTOR) want.code = classify_insn(in_ch.instruction_word);
      else                          want.code = CODE_W'(row_code);
      want.supported = want.code != T_NONE;
      template_q.push_back(want);
      words_in++;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.code      = out_ch.template_code;
      got.supported = out_ch.supported;
      results_checked++;
      if (!$isunknown(got.code)) codes_seen[got.code] = 1'b1;
      if (template_q.size() == 0) begin
        note_mismatch("unexpected result, template_code", -1, got.code);
      end else begin
        want = template_q.pop_front();
        if (got.code !== want.code) note_mismatch("template_code", want.code, got.code);
        if (got.supported !== want.supported)
          note_mismatch("supported", want.supported, got.supported);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("arm_insn_pc_use_classifier_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni                 <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.instruction_word <= '0;
    row_code               <= BY_PREDICTOR;
    src_idle_on             = 1'b1;
    snk_stall_on            = 1'b1;
    fail_count              = 0;
    words_in                = 0;
    results_checked         = 0;
    quiet_cycles            = 0;
    codes_seen              = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows first, idling on both sides
    for (int i = 0; i < NDIR; i++) offer_word(DIR_WORD[i], DIR_CODE[i]);
    for (int i = 0; i < RANDOM_PHASE_A; i++) offer_word(shape_insn_word(), BY_PREDICTOR);

    // Hold off the sender until the pipeline is empty, then restart from cold
    drain_templates();
    for (int i = 0; i < RANDOM_PHASE_B; i++) offer_word(shape_insn_word(), BY_PREDICTOR);

    // Last stretch at full rate: no idling on either side
    src_idle_on  = 1'b0;
    snk_stall_on = 1'b0;
    for (int i = 0; i < RANDOM_PHASE_C; i++) offer_word(shape_insn_word(), BY_PREDICTOR);

    drain_templates();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Classified %0d words (%0d directed, %0d shaped random); %0d results checked.",
             words_in, NDIR, RANDOM_PHASE_A + RANDOM_PHASE_B + RANDOM_PHASE_C,
             results_checked);
    $display("Template codes observed: %0d of 15; mismatches: %0d.",
             $countones(codes_seen[14:0]), fail_count);
    if (fail_count == 0 && template_q.size() == 0) begin
      $display("arm_insn_pc_use_classifier_unit test passed");
    end else begin
      $display("arm_insn_pc_use_classifier_unit test failed");
    end
    $finish;
  end

endmodule

[files.f]
src/aipc_pkg.sv
src/aipc_if.sv
src/aipc_match.sv
src/aipc_pred.sv
src/aipc_code.sv
src/arm_insn_pc_use_classifier_unit.sv
dv/tb_arm_insn_pc_use_classifier_unit.sv
